@@ rtl/olla_pkg.sv @@
`default_nettype none

package olla_pkg;

	// User table geometry.
	localparam int SLOTS   = 32;
	localparam int SLOT_AW = $clog2(SLOTS);
	localparam logic [SLOT_AW:0]   SLOT_END  = (SLOT_AW + 1)'(SLOTS);
	localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SLOTS - 1);

	// Threshold store: two tables of 32 entries, addressed {table_sel, mcs}.
	localparam int THR_DEPTH = 64;
	localparam int THR_AW    = $clog2(THR_DEPTH);

	localparam logic [6:0]         FB_MAX     = 7'd64;
	localparam logic [4:0]         MCS_MAX_T0 = 5'd28;
	localparam logic [4:0]         MCS_MAX_T1 = 5'd27;
	localparam logic signed [23:0] THR_RESET  = -24'sd6488064;
	localparam logic signed [24:0] OFF_LIMIT  = 25'sd1966080;

	// Configuration register indexes.
	localparam logic [2:0] CFG_NACK_STEP  = 3'd0;
	localparam logic [2:0] CFG_ACK_STEP   = 3'd1;
	localparam logic [2:0] CFG_MCS_CAP    = 3'd2;
	localparam logic [2:0] CFG_MIN_MCS    = 3'd3;
	localparam logic [2:0] CFG_UPD_PERIOD = 3'd4;

	localparam logic [15:0] RST_NACK_STEP  = 16'd3277;
	localparam logic [15:0] RST_ACK_STEP   = 16'd364;
	localparam logic [4:0]  RST_MCS_CAP    = 5'd28;
	localparam logic [4:0]  RST_MIN_MCS    = 5'd0;
	localparam logic [10:0] RST_UPD_PERIOD = 11'd1;

	typedef enum logic [1:0] {
		RK_WRITE = 2'd0,
		RK_SKIP  = 2'd1,
		RK_FEED  = 2'd2
	} res_kind_t;

	typedef struct packed {
		logic              func;
		logic [15:0]       user_id;
		logic              table_sel;
		logic [4:0]        entry_mcs;
		logic signed [23:0] entry_threshold;
		logic [6:0]        ack_cnt;
		logic [6:0]        nack_cnt;
		logic [4:0]        prev_mcs;
		logic [9:0]        frames_since_update;
	} item_t;

	typedef struct packed {
		logic [15:0]        user;
		logic signed [21:0] offset;
		logic [31:0]        stamp;
	} slot_ent_t;

	typedef struct packed {
		logic      load;
		logic      thr_wr;
		logic      scan_init;
		logic      scan;
		logic      mul;
		logic      sum;
		logic      slot_wr;
		logic      thr_amax;
		logic      eff_ld;
		logic      sr_step;
		logic      out_load;
		res_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic skip;
		logic scan_done;
		logic found;
		logic at_lo;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/olla_mcs_selector_unit.sv @@
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata (75 bits used of 80), s_tuser = func
// m_        out  m_tvalid/m_tready   m_tdata (54 bits used of 56)
// cfg_      in   cfg_valid/cfg_ready cfg_index (register), cfg_data
//
// One request is worked on at a time. A threshold write, and a request with no
// update due, pass from decode straight to the done state. A feedback request
// first scans all 32 user slots (one RAM read a cycle), then compares 1 to 29
// thresholds in a search loop over the SRD and SCMP states.
// The reset is asynchronous and active low; it clears all control state, the
// slot and threshold valid bits and the access counter, so no clearing pass runs.
// A result waits in the output register while m_tready is low; the next request
// is accepted meanwhile, but its result is held until the register frees.
`default_nettype none

module olla_mcs_selector_unit
	import olla_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input request.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// From bit 0: user_id[15:0], table_sel[16], entry_mcs[21:17],
	// entry_threshold[45:22], ack_cnt[52:46], nack_cnt[59:53],
	// prev_mcs[64:60], frames_since_update[74:65], zero fill.
	input  wire logic [79:0] s_tdata,
	// func: 0 threshold write, 1 feedback and select.
	input  wire logic        s_tuser,
	// Result.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// From bit 0: mcs[4:0], offset_now[26:5], eff_snr[51:27],
	// updated[52], evicted[53], zero fill.
	output logic [55:0]      m_tdata,
	// Configuration write.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	item_t       item;
	cmd_t        cmd;
	stat_t       st;
	logic [4:0]  res_mcs;
	logic [21:0] res_offset;
	logic [24:0] res_eff;
	logic        res_updated, res_evicted;

	// The configuration registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	assign item = '{
		func:                s_tuser,
		user_id:             s_tdata[15:0],
		table_sel:           s_tdata[16],
		entry_mcs:           s_tdata[21:17],
		entry_threshold:     s_tdata[45:22],
		ack_cnt:             s_tdata[52:46],
		nack_cnt:            s_tdata[59:53],
		prev_mcs:            s_tdata[64:60],
		frames_since_update: s_tdata[74:65]
	};

	olla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	olla_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.res_mcs     (res_mcs),
		.res_offset  (res_offset),
		.res_eff     (res_eff),
		.res_updated (res_updated),
		.res_evicted (res_evicted)
	);

	assign m_tdata = {2'b00, res_evicted, res_updated, res_eff, res_offset, res_mcs};

endmodule

`default_nettype wire

@@ rtl/olla_ram.sv @@
`default_nettype none

module olla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/olla_ctrl.sv @@
`default_nettype none

module olla_ctrl
	import olla_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t st,
	output cmd_t       cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DECODE = 10'b0000000010,
		ST_SCAN   = 10'b0000000100,
		ST_MUL    = 10'b0000001000,
		ST_SUM    = 10'b0000010000,
		ST_WRSLOT = 10'b0000100000,
		ST_EFF    = 10'b0001000000,
		ST_SRD    = 10'b0010000000,
		ST_SCMP   = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= RK_WRITE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.out_kind = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!st.func) begin
					cmd.thr_wr = 1'b1;
					kind_d     = RK_WRITE;
					state_d    = ST_DONE;
				end else if (st.skip) begin
					kind_d  = RK_SKIP;
					state_d = ST_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					kind_d        = RK_FEED;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_WRSLOT;
			end
			ST_WRSLOT: begin
				cmd.slot_wr  = 1'b1;
				cmd.thr_amax = 1'b1;
				state_d      = ST_EFF;
			end
			ST_EFF: begin
				cmd.eff_ld = 1'b1;
				state_d    = ST_SRD;
			end
			ST_SRD: begin
				state_d = ST_SCMP;
			end
			ST_SCMP: begin
				cmd.sr_step = 1'b1;
				if (st.found || st.at_lo) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SRD;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/olla_dp.sv @@
`default_nettype none

module olla_dp
	import olla_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_t       item,
	input  wire logic        cfg_valid,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire cmd_t        cmd,
	output stat_t            st,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [4:0]       res_mcs,
	output logic [21:0]      res_offset,
	output logic [24:0]      res_eff,
	output logic             res_updated,
	output logic             res_evicted
);

	item_t it_q;

	logic [15:0] nack_step_q, ack_step_q;
	logic [4:0]  mcs_cap_q, min_mcs_q;
	logic [10:0] period_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nack_step_q <= RST_NACK_STEP;
			ack_step_q  <= RST_ACK_STEP;
			mcs_cap_q   <= RST_MCS_CAP;
			min_mcs_q   <= RST_MIN_MCS;
			period_q    <= RST_UPD_PERIOD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NACK_STEP:  nack_step_q <= cfg_data;
				CFG_ACK_STEP:   ack_step_q  <= cfg_data;
				CFG_MCS_CAP:    mcs_cap_q   <= cfg_data[4:0];
				CFG_MIN_MCS:    min_mcs_q   <= cfg_data[4:0];
				CFG_UPD_PERIOD: period_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Per-item decode.
	logic [6:0]  acks_c, nacks_c;
	logic [4:0]  tmax_c, amax_c, lo_c, hi_c;
	logic [15:0] uid_c;

	always_comb begin
		acks_c  = (it_q.ack_cnt > FB_MAX) ? FB_MAX : it_q.ack_cnt;
		nacks_c = (it_q.nack_cnt > FB_MAX) ? FB_MAX : it_q.nack_cnt;
		tmax_c  = it_q.table_sel ? MCS_MAX_T1 : MCS_MAX_T0;
		amax_c  = (mcs_cap_q < tmax_c) ? mcs_cap_q : tmax_c;
		uid_c   = (it_q.user_id == 16'd0) ? 16'd1 : it_q.user_id;
		if (min_mcs_q > amax_c) begin
			lo_c = 5'd0;
			hi_c = tmax_c;
		end else begin
			lo_c = min_mcs_q;
			hi_c = amax_c;
		end
	end

	assign st.func = it_q.func;
	assign st.skip = (it_q.ack_cnt == 7'd0) && (it_q.nack_cnt == 7'd0)
		&& ({1'b0, it_q.frames_since_update} < period_q);

	// User table.
	logic [31:0]        aclk_q;
	logic [SLOTS-1:0]   slot_valid_q;
	logic [SLOT_AW:0]   cnt_q;
	logic               rv_q, sv_q;
	logic [SLOT_AW-1:0] ridx_q;
	slot_ent_t          slot_rd, slot_wd, ent_c;
	logic               issue_c;

	logic               hit_q, free_q;
	logic [SLOT_AW-1:0] hit_idx_q, free_idx_q, lru_idx_q, slot_sel_q;
	logic [31:0]        lru_stamp_q;
	logic signed [21:0] hit_off_q;

	assign issue_c = cmd.scan && (cnt_q != SLOT_END);

	olla_ram #(.WIDTH($bits(slot_ent_t)), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (cmd.slot_wr),
		.waddr (slot_sel_q),
		.wdata (slot_wd),
		.raddr (cnt_q[SLOT_AW-1:0]),
		.rdata (slot_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aclk_q       <= '0;
			slot_valid_q <= '0;
			cnt_q        <= '0;
			rv_q         <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				aclk_q <= aclk_q + 32'd1;
				cnt_q  <= '0;
				rv_q   <= 1'b0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				rv_q <= issue_c;
				if (issue_c) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (rv_q && !hit_q && sv_q && (ent_c.user == uid_c)) begin
					hit_q <= 1'b1;
				end
				if (rv_q && !free_q && !sv_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.slot_wr) begin
				slot_valid_q[slot_sel_q] <= 1'b1;
			end
		end
	end

	// A slot never written reads as a free, zeroed entry.
	assign ent_c = sv_q ? slot_rd : '0;

	always_ff @(posedge clk) begin
		if (issue_c) begin
			ridx_q <= cnt_q[SLOT_AW-1:0];
			sv_q   <= slot_valid_q[cnt_q[SLOT_AW-1:0]];
		end
		if (rv_q) begin
			if (!hit_q && sv_q && (ent_c.user == uid_c)) begin
				hit_idx_q <= ridx_q;
				hit_off_q <= ent_c.offset;
			end
			if (!free_q && !sv_q) begin
				free_idx_q <= ridx_q;
			end
			if ((ridx_q == '0) || (ent_c.stamp < lru_stamp_q)) begin
				lru_idx_q   <= ridx_q;
				lru_stamp_q <= ent_c.stamp;
			end
		end
	end

	assign st.scan_done = rv_q && (ridx_q == SLOT_LAST);

	// Offset update.
	logic [22:0]        pn_q, pa_q;
	logic signed [21:0] base_q, off_q;
	logic               ev_q;
	logic signed [24:0] sum_c;

	assign slot_wd = '{user: uid_c, offset: off_q, stamp: aclk_q};

	assign sum_c = $signed({{3{base_q[21]}}, base_q}) - $signed({2'b00, pn_q})
		+ $signed({2'b00, pa_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pn_q <= 23'(nacks_c) * 23'(nack_step_q);
			pa_q <= 23'(acks_c) * 23'(ack_step_q);
			if (hit_q) begin
				slot_sel_q <= hit_idx_q;
				base_q     <= hit_off_q;
				ev_q       <= 1'b0;
			end else if (free_q) begin
				slot_sel_q <= free_idx_q;
				base_q     <= '0;
				ev_q       <= 1'b0;
			end else begin
				slot_sel_q <= lru_idx_q;
				base_q     <= '0;
				ev_q       <= 1'b1;
			end
		end
		if (cmd.sum) begin
			if (sum_c > OFF_LIMIT) begin
				off_q <= OFF_LIMIT[21:0];
			end else if (sum_c < -OFF_LIMIT) begin
				off_q <= 22'(-OFF_LIMIT);
			end else begin
				off_q <= sum_c[21:0];
			end
		end
	end

	// Threshold store and MCS search.
	logic [THR_DEPTH-1:0] thr_valid_q;
	logic [THR_AW-1:0]    thr_raddr_c;
	logic [23:0]          thr_q;
	logic                 thr_v_q;
	logic signed [23:0]   thr_rd_c;
	logic signed [24:0]   eff_q;
	logic [4:0]           m_q, sel_q;

	assign thr_raddr_c = cmd.thr_amax ? {it_q.table_sel, amax_c} : {it_q.table_sel, m_q};

	olla_ram #(.WIDTH(24), .DEPTH(THR_DEPTH)) u_thr_ram (
		.clk   (clk),
		.we    (cmd.thr_wr),
		.waddr ({it_q.table_sel, it_q.entry_mcs}),
		.wdata (it_q.entry_threshold),
		.raddr (thr_raddr_c),
		.rdata (thr_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_valid_q <= '0;
		end else if (cmd.thr_wr) begin
			thr_valid_q[{it_q.table_sel, it_q.entry_mcs}] <= 1'b1;
		end
	end

	assign thr_rd_c = thr_v_q ? $signed(thr_q) : THR_RESET;
	assign st.found = eff_q > $signed({thr_rd_c[23], thr_rd_c});
	assign st.at_lo = (m_q == lo_c);

	always_ff @(posedge clk) begin
		thr_v_q <= thr_valid_q[thr_raddr_c];
		if (cmd.eff_ld) begin
			eff_q <= $signed({thr_rd_c[23], thr_rd_c}) + $signed({{3{off_q[21]}}, off_q});
			m_q   <= hi_c;
		end
		if (cmd.sr_step) begin
			if (st.found) begin
				sel_q <= m_q;
			end else if (st.at_lo) begin
				sel_q <= lo_c;
			end else begin
				m_q <= m_q - 5'd1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	assign st.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				RK_FEED: begin
					res_mcs     <= sel_q;
					res_offset  <= off_q;
					res_eff     <= eff_q;
					res_updated <= 1'b1;
					res_evicted <= ev_q;
				end
				RK_SKIP: begin
					res_mcs     <= (it_q.prev_mcs < amax_c) ? it_q.prev_mcs : amax_c;
					res_offset  <= '0;
					res_eff     <= '0;
					res_updated <= 1'b0;
					res_evicted <= 1'b0;
				end
				default: begin
					res_mcs     <= '0;
					res_offset  <= '0;
					res_eff     <= '0;
					res_updated <= 1'b0;
					res_evicted <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/olla_chk.sv @@
`default_nettype none

module olla_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Only one request is in work at a time.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// The selected MCS never exceeds the larger table's maximum.
	a_mcs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] <= 5'd28)
		else $error("mcs out of range");

	// Without an update the offset and effective SNR read zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[52] |-> m_tdata[51:5] == '0 && !m_tdata[53])
		else $error("non-update result carries data");

	// The offset stays within plus or minus 30 dB.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[26:5]) <= 22'sd1966080
			&& $signed(m_tdata[26:5]) >= -22'sd1966080)
		else $error("offset out of range");

endmodule

bind olla_mcs_selector_unit olla_chk u_chk (.*);

`default_nettype wire
